// ===== rtl/imu_frame_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the frame parser top level.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_PARSER_TOP_MACROS_SVH
`define IMU_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IMUFP_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("imufp: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define IMUFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("imufp: next-cycle check failed");

`endif

// ===== rtl/imufp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imufp_pkg
// Shared types, constants and helper functions of the IMU frame parser.
// ----------------------------------------------------------------------------
package imufp_pkg;

	localparam int DEF_FRAME_BYTES = 11;
	localparam int VALUE_W         = 27;
	localparam int WORD_W          = 16;
	localparam int SCALE_W         = 12;

	localparam logic [7:0] SYNC_BYTE  = 8'h55;
	localparam logic [7:0] TYPE_MASK  = 8'h50;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;

	typedef enum logic [1:0] {
		KIND_ACCEL = 2'd0,
		KIND_RATE  = 2'd1,
		KIND_ANGLE = 2'd2,
		KIND_OTHER = 2'd3
	} frame_kind_t;

	// One cell of the byte window: a byte and a flag saying it belongs to the
	// current candidate frame.
	typedef struct packed {
		logic       vld;
		logic [7:0] data;
	} cell_t;

	// A frame that passed all checks, as handed to the scaling stages.
	typedef struct packed {
		frame_kind_t       kind;
		logic [7:0]        type_byte;
		logic [WORD_W-1:0] word_x;
		logic [WORD_W-1:0] word_y;
		logic [WORD_W-1:0] word_z;
	} frame_t;

	function automatic frame_kind_t kind_of(input logic [7:0] type_byte);
		frame_kind_t k;
		case (type_byte)
			TYPE_ACCEL: k = KIND_ACCEL;
			TYPE_RATE:  k = KIND_RATE;
			TYPE_ANGLE: k = KIND_ANGLE;
			default:    k = KIND_OTHER;
		endcase
		return k;
	endfunction

	// Scale factor in units of 1/32768 for each frame kind.
	function automatic logic signed [SCALE_W-1:0] scale_of(input frame_kind_t kind);
		logic signed [SCALE_W-1:0] s;
		case (kind)
			KIND_ACCEL: s = 12'sd16;
			KIND_RATE:  s = 12'sd2000;
			KIND_ANGLE: s = 12'sd180;
			default:    s = 12'sd1;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/imu_frame_parser_top.sv =====
`timescale 1ns / 1ps
// A result is offered after the last byte of a good frame is transferred, once it
// has passed the frame capture register and been scaled into the output register.
// Throughput: one byte per cycle while in_stall is low; the row of window
// cells shifts on every input transfer, and the two result stages overlap
// with the next frame. Reset (arst_n low, asynchronous) empties the window,
// zeroes the checksum and drops any result in flight.
// ----------------------------------------------------------------------------
// imu_frame_parser_top
// Serial byte parser for 11-byte IMU frames with fixed-point scaled outputs.
// ----------------------------------------------------------------------------
`include "imu_frame_parser_top_macros.svh"

module imu_frame_parser_top import imufp_pkg::*; #(
	parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                frame_kind,
	output logic [7:0]                type_byte,
	output logic signed [VALUE_W-1:0] value_x,
	output logic signed [VALUE_W-1:0] value_y,
	output logic signed [VALUE_W-1:0] value_z
);

	logic   in_xfer;
	logic   frame_good;
	logic   busy;
	logic   any_neg;
	frame_t frame;

	// The input stalls only when the capture register holds a frame that the
	// output register cannot take yet. A byte that completes no frame would not
	// need that space, but the stall is kept independent of the byte value.
	assign in_stall = busy;
	assign in_xfer  = in_valid && !in_stall;

	// Byte window: a row of cells, one per stored byte, shifting on each
	// transfer, with the checksum kept as a running sum beside it.
	imufp_window #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.shift      (in_xfer),
		.rx_byte    (rx_byte),
		.frame_good (frame_good),
		.frame      (frame)
	);

	// Result pipe: the good frame is captured, then its three words are scaled
	// by the constant of its kind into the output register.
	imufp_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_xfer && frame_good),
		.frame      (frame),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_kind (frame_kind),
		.type_byte  (type_byte),
		.value_x    (value_x),
		.value_y    (value_y),
		.value_z    (value_z)
	);

	// High when any of the three output values carries a set sign bit.
	assign any_neg = value_x[VALUE_W-1] | value_y[VALUE_W-1] | value_z[VALUE_W-1];

	// Every emitted frame carried both type bits of the mask.
	`IMUFP_ASSERT_IMPLY(a_type_bits, out_valid, (type_byte & TYPE_MASK) == TYPE_MASK)
	// The kind must agree with the raw type byte it was decoded from.
	`IMUFP_ASSERT_IMPLY(a_kind_match, out_valid, frame_kind == 2'(kind_of(type_byte)))
	// Angle words are unsigned, so their scaled values are never negative.
	`IMUFP_ASSERT_IMPLY(a_angle_pos, out_valid && frame_kind == KIND_ANGLE, !any_neg)
	// A frame accepted into capture while the output is empty must be offered
	// once it has moved from the capture register into the output register.
	`IMUFP_ASSERT_NEXT(a_frame_out, in_xfer && frame_good && !out_valid, ##1 out_valid)

endmodule

// ===== rtl/imufp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imufp_cell
// One stage of the byte window: takes its neighbor's byte on every transfer.
// ----------------------------------------------------------------------------
module imufp_cell import imufp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  logic  clear,
	input  cell_t cell_in,
	output cell_t cell_q
);

	// The byte resets to zero so that the window's running sum starts out right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (shift) begin
			cell_q.data <= cell_in.data;
			cell_q.vld  <= cell_in.vld & ~clear;
		end
	end

endmodule

// ===== rtl/imufp_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imufp_window
// Row of byte cells with a running checksum and the frame acceptance checks.
// ----------------------------------------------------------------------------
module imufp_window import imufp_pkg::*; #(
	parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [7:0] rx_byte,
	output logic       frame_good,
	output frame_t     frame
);

	localparam int WIN_DEPTH = FRAME_BYTES - 1;

	cell_t      cells [WIN_DEPTH];
	cell_t      feed  [WIN_DEPTH];
	logic [7:0] sum_q;
	logic       clear;

	// Bytes enter at the top cell and move one cell down per transfer; cell 0
	// holds the oldest byte of the candidate frame once the window is full.
	for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
		if (i == WIN_DEPTH - 1) begin : g_top
			assign feed[i] = '{vld: 1'b1, data: rx_byte};
		end else begin : g_mid
			assign feed[i] = cells[i+1];
		end
		imufp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.clear   (clear),
			.cell_in (feed[i]),
			.cell_q  (cells[i])
		);
	end

	// The sum covers every cell, valid or not; once the window is full it is
	// exactly the checksum of the ten stored frame bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift) begin
			sum_q <= sum_q + rx_byte - cells[0].data;
		end
	end

	always_comb begin
		frame_good = cells[0].vld
			&& (cells[0].data == SYNC_BYTE)
			&& ((cells[1].data & TYPE_MASK) == TYPE_MASK)
			&& (sum_q == rx_byte);
		frame.kind      = kind_of(cells[1].data);
		frame.type_byte = cells[1].data;
		frame.word_x    = {cells[3].data, cells[2].data};
		frame.word_y    = {cells[5].data, cells[4].data};
		frame.word_z    = {cells[7].data, cells[6].data};
	end

	// A good frame empties the window; a bad one just slides it by one byte.
	assign clear = frame_good;

endmodule

// ===== rtl/imufp_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imufp_scale
// Two-stage result pipe: frame capture, then constant scaling into the
// output register.
// ----------------------------------------------------------------------------
module imufp_scale import imufp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  frame_t                    frame,
	output logic                      busy,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                frame_kind,
	output logic [7:0]                type_byte,
	output logic signed [VALUE_W-1:0] value_x,
	output logic signed [VALUE_W-1:0] value_y,
	output logic signed [VALUE_W-1:0] value_z
);

	frame_t frame_s1;
	logic   vld_s1;
	logic   s2_take;

	function automatic logic signed [VALUE_W-1:0] scale_word(
		input logic [WORD_W-1:0] w,
		input frame_kind_t       kind
	);
		logic signed [WORD_W:0]              op;
		logic signed [WORD_W+SCALE_W:0]      prod;
		op   = (kind == KIND_ANGLE) ? $signed({1'b0, w}) : $signed({w[WORD_W-1], w});
		prod = op * scale_of(kind);
		return prod[VALUE_W-1:0];
	endfunction

	assign s2_take = !out_valid || !out_stall;
	assign busy    = vld_s1 && !s2_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!busy) begin
			vld_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !busy) begin
			frame_s1 <= frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_take) begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take && vld_s1) begin
			frame_kind <= frame_s1.kind;
			type_byte  <= frame_s1.type_byte;
			value_x    <= scale_word(frame_s1.word_x, frame_s1.kind);
			value_y    <= scale_word(frame_s1.word_y, frame_s1.kind);
			value_z    <= scale_word(frame_s1.word_z, frame_s1.kind);
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the serial IMU frame parser against a byte-level software parser.
// A stream of bytes is sent, mostly well-formed frames with random words, with
// bad frames and noise mixed in. Each accepted byte goes through a local
// parser, and every decoded frame it produces must match the next result
// transfer, field by field.
// ----------------------------------------------------------------------------
module testbench;
	import imufp_pkg::*;

	localparam int FRAME_LEN     = 11;
	localparam int WIN_LEN       = FRAME_LEN - 1;
	localparam int ACCEL_SCALE   = 16;
	localparam int RATE_SCALE    = 2000;
	localparam int ANGLE_SCALE   = 180;
	localparam int RAW_SCALE     = 1;
	localparam int RANDOM_BYTES  = 620;
	localparam int HOLD_CYCLES   = 200;
	localparam int DRAIN_CYCLES  = 8;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int REPORT_LIMIT  = 10;

	// Ways in which a test frame can be spoiled on purpose.
	typedef enum int {
		FLAW_NONE,
		FLAW_START,
		FLAW_TYPE,
		FLAW_SUM
	} frame_flaw_t;

	// One decoded frame as the block should present it.
	typedef struct {
		frame_kind_t               kind;
		logic [7:0]                tbyte;
		logic signed [VALUE_W-1:0] vx;
		logic signed [VALUE_W-1:0] vy;
		logic signed [VALUE_W-1:0] vz;
	} imu_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [7:0]                rx_byte;
	logic                      out_valid;
	logic                      out_stall;
	logic [1:0]                frame_kind;
	logic [7:0]                type_byte;
	logic signed [VALUE_W-1:0] value_x;
	logic signed [VALUE_W-1:0] value_y;
	logic signed [VALUE_W-1:0] value_z;

	// Local copy of the parser state: the stored bytes and how many are valid.
	logic [7:0] win [WIN_LEN];
	int         win_fill;

	// Decoded frames waiting for their result transfer, oldest first.
	imu_result_t pending_frames [$];

	// Shared controls: idle_on enables random gaps on both sides, hold_req
	// asks the receiver for one long stall.
	bit idle_on;
	bit hold_req;

	int fail_count;
	int bytes_sent;
	int results_seen;
	int kind_seen [4];

	imu_frame_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_kind (frame_kind),
		.type_byte  (type_byte),
		.value_x    (value_x),
		.value_y    (value_y),
		.value_z    (value_z)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run; a correct run ends well before this.
	initial begin
		#2000000;
		$display("testbench: done, errors");
		$finish;
	end

	// Scales one little-endian word the way the frame kind asks. Angle words
	// are unsigned, all others are two's complement. The product is kept at
	// the output width.
	function automatic logic signed [VALUE_W-1:0] scaled_word(input frame_kind_t k,
			input logic [15:0] w);
		int v;
		int s;
		int p;
		case (k)
			KIND_ACCEL: s = ACCEL_SCALE;
			KIND_RATE:  s = RATE_SCALE;
			KIND_ANGLE: s = ANGLE_SCALE;
			default:    s = RAW_SCALE;
		endcase
		if (k == KIND_ANGLE) begin
			v = {16'h0000, w};
		end else begin
			v = {{16{w[15]}}, w};
		end
		p = v * s;
		return p[VALUE_W-1:0];
	endfunction

	// Feeds one byte to the local parser. Returns 1 and the decoded frame when
	// the byte completes a good frame. A bad frame drops its oldest byte so
	// the search for the sync byte slides on by one.
	function automatic bit parse_byte(input logic [7:0] b, output imu_result_t r);
		logic [7:0]  fr [FRAME_LEN];
		logic [7:0]  sum;
		frame_kind_t k;
		int          i;
		r.kind  = KIND_OTHER;
		r.tbyte = 8'h00;
		r.vx    = '0;
		r.vy    = '0;
		r.vz    = '0;
		if (win_fill < WIN_LEN) begin
			win[win_fill] = b;
			win_fill++;
			return 1'b0;
		end
		for (i = 0; i < WIN_LEN; i++) fr[i] = win[i];
		fr[WIN_LEN] = b;
		sum = 8'h00;
		for (i = 0; i < WIN_LEN; i++) sum = sum + fr[i];
		if (fr[0] != SYNC_BYTE || (fr[1] & TYPE_MASK) != TYPE_MASK || sum != fr[WIN_LEN]) begin
			for (i = 0; i < WIN_LEN; i++) win[i] = fr[i + 1];
			return 1'b0;
		end
		win_fill = 0;
		case (fr[1])
			TYPE_ACCEL: k = KIND_ACCEL;
			TYPE_RATE:  k = KIND_RATE;
			TYPE_ANGLE: k = KIND_ANGLE;
			default:    k = KIND_OTHER;
		endcase
		r.kind  = k;
		r.tbyte = fr[1];
		r.vx    = scaled_word(k, {fr[3], fr[2]});
		r.vy    = scaled_word(k, {fr[5], fr[4]});
		r.vz    = scaled_word(k, {fr[7], fr[6]});
		return 1'b1;
	endfunction

	// Sends one byte. A random gap, which may be empty, goes first when
	// idling is on; in_valid is only lowered when there is a gap, so a
	// back-to-back byte never sees valid dropped and raised in one step.
	// The byte is transferred at the first edge with in_stall low.
	task automatic send_byte(input logic [7:0] b);
		int          gap;
		imu_result_t res;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		if (parse_byte(b, res)) pending_frames.push_back(res);
	endtask

	// Builds an 11-byte frame with the right checksum, spoils it as asked and
	// sends it. Bytes 8 and 9 only feed the checksum, so they are random.
	task automatic send_frame(input logic [7:0] tbyte, input logic [15:0] wx,
			input logic [15:0] wy, input logic [15:0] wz, input frame_flaw_t flaw);
		logic [7:0] f [FRAME_LEN];
		logic [7:0] sum;
		logic [7:0] flip;
		int         i;
		flip = 8'($urandom_range(1, 255));
		f[0] = SYNC_BYTE;
		f[1] = tbyte;
		f[2] = wx[7:0];
		f[3] = wx[15:8];
		f[4] = wy[7:0];
		f[5] = wy[15:8];
		f[6] = wz[7:0];
		f[7] = wz[15:8];
		f[8] = 8'($urandom_range(0, 255));
		f[9] = 8'($urandom_range(0, 255));
		if (flaw == FLAW_START) f[0] = SYNC_BYTE ^ flip;
		if (flaw == FLAW_TYPE) begin
			// Clear one or both of the required type bits.
			case ($urandom_range(0, 2))
				0:       f[1] = tbyte & ~8'h10;
				1:       f[1] = tbyte & ~8'h40;
				default: f[1] = tbyte & ~TYPE_MASK;
			endcase
		end
		sum = 8'h00;
		for (i = 0; i < WIN_LEN; i++) sum = sum + f[i];
		f[WIN_LEN] = (flaw == FLAW_SUM) ? (sum ^ flip) : sum;
		for (i = 0; i < FRAME_LEN; i++) send_byte(f[i]);
	endtask

	// Waits until every decoded frame has been seen at the output.
	task automatic wait_drained();
		while (pending_frames.size() != 0) @(posedge clk);
	endtask

	// Random axis word that hits the extremes now and then.
	function automatic logic [15:0] random_word();
		case ($urandom_range(0, 15))
			0:       return 16'h0000;
			1:       return 16'h7FFF;
			2:       return 16'h8000;
			3:       return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Type byte for a good frame: one of the three known kinds or any other
	// byte that carries both required bits.
	function automatic logic [7:0] random_type();
		case ($urandom_range(0, 3))
			0:       return TYPE_ACCEL;
			1:       return TYPE_RATE;
			2:       return TYPE_ANGLE;
			default: return 8'($urandom_range(0, 255)) | TYPE_MASK;
		endcase
	endfunction

	// Every kind, with the word extremes spread among them: most negative, most
	// positive, all ones (the largest angle) and zero.
	task automatic test_kinds_and_extremes();
		send_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFF, FLAW_NONE);
		send_frame(TYPE_RATE,  16'h8000, 16'h7FFF, 16'h0001, FLAW_NONE);
		send_frame(TYPE_ANGLE, 16'hFFFF, 16'h8000, 16'h0000, FLAW_NONE);
		send_frame(8'hF0,      16'h1234, 16'hFEDC, 16'h8000, FLAW_NONE);
		send_frame(TYPE_MASK,  16'h7FFF, 16'hFFFF, 16'h0000, FLAW_NONE);
	endtask

	// A frame with a wrong sync byte, one with missing type bits and one with
	// a wrong checksum, each followed by a good frame that must be found after
	// the parser has slid past the bad one.
	task automatic test_bad_frames();
		send_frame(TYPE_ACCEL, 16'h0102, 16'h0304, 16'h0506, FLAW_START);
		send_frame(TYPE_RATE,  16'hA5A5, 16'h5A5A, 16'hC3C3, FLAW_NONE);
		send_frame(TYPE_ANGLE, 16'h1111, 16'h2222, 16'h3333, FLAW_TYPE);
		send_frame(TYPE_ANGLE, 16'h4444, 16'h5555, 16'h6666, FLAW_NONE);
		send_frame(TYPE_ACCEL, 16'h7777, 16'h8888, 16'h9999, FLAW_SUM);
		send_frame(TYPE_ACCEL, 16'hAAAA, 16'hBBBB, 16'hCCCC, FLAW_NONE);
	endtask

	// Stray bytes, false sync bytes among them, ahead of a good frame.
	task automatic test_noise_resync();
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(TYPE_ACCEL);
		send_byte(8'hFF);
		send_frame(TYPE_RATE, 16'hFFFF, 16'h0000, 16'h8001, FLAW_NONE);
	endtask

	// The receiver stalls for a long stretch while frames keep arriving back
	// to back, so the result stages fill and the input has to stall too.
	task automatic test_output_backpressure();
		int i;
		idle_on  = 1'b0;
		hold_req = 1'b1;
		for (i = 0; i < 6; i++) begin
			send_frame(random_type(), random_word(), random_word(), random_word(), FLAW_NONE);
		end
		wait_drained();
		idle_on = 1'b1;
	endtask

	// The sender stops until every result is out, then starts again.
	task automatic test_sender_pause();
		send_frame(TYPE_ANGLE, random_word(), random_word(), random_word(), FLAW_NONE);
		wait_drained();
		send_frame(TYPE_ACCEL, random_word(), random_word(), random_word(), FLAW_NONE);
	endtask

	// Random stream: mostly good frames with random content, some spoiled
	// frames and some bursts of noise. Idling is switched on and off in
	// stretches, and now and then the sender waits for the output to drain.
	task automatic test_random_stream();
		int          start;
		int          pick;
		int          n;
		int          i;
		frame_flaw_t flaw;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if ($urandom_range(0, 7) == 0) idle_on = ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(random_type(), random_word(), random_word(), random_word(),
					FLAW_NONE);
			end else if (pick < 85) begin
				case ($urandom_range(0, 2))
					0:       flaw = FLAW_START;
					1:       flaw = FLAW_TYPE;
					default: flaw = FLAW_SUM;
				endcase
				send_frame(random_type(), random_word(), random_word(), random_word(), flaw);
			end else begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) begin
					send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255)));
				end
			end
			if ($urandom_range(0, 24) == 0) wait_drained();
		end
		idle_on = 1'b1;
	endtask

	// Receiver: before each result it may raise out_stall at random when
	// idling is on, then stays ready until a transfer happens or a long hold
	// is asked for. The long hold is counted here in cycles.
	initial begin : receiver
		int n;
		out_stall = 1'b0;
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			n = idle_on ? $urandom_range(0, 3) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid && !hold_req);
		end
	end

	// Result checker: every transfer is compared with the oldest decoded
	// frame. Values are read as they stood before the edge.
	always @(posedge clk) begin
		imu_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT) begin
					$display("testbench: result with nothing expected: kind %0d type %02h x %0d y %0d z %0d",
						frame_kind, type_byte, value_x, value_y, value_z);
				end
			end else begin
				want = pending_frames.pop_front();
				results_seen++;
				kind_seen[want.kind]++;
				if (frame_kind !== want.kind || type_byte !== want.tbyte ||
						value_x !== want.vx || value_y !== want.vy || value_z !== want.vz) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("testbench: mismatch: want kind %0d type %02h x %0d y %0d z %0d",
							want.kind, want.tbyte, want.vx, want.vy, want.vz);
						$display("testbench:           got  kind %0d type %02h x %0d y %0d z %0d",
							frame_kind, type_byte, value_x, value_y, value_z);
					end
				end
			end
		end
	end

	initial begin
		int waited;
		in_valid   = 1'b0;
		rx_byte    = 8'h00;
		arst_n     = 1'b0;
		idle_on    = 1'b1;
		hold_req   = 1'b0;
		fail_count = 0;
		bytes_sent = 0;
		results_seen = 0;
		kind_seen  = '{default: 0};
		win        = '{default: 8'h00};
		win_fill   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_kinds_and_extremes();
		test_bad_frames();
		test_noise_resync();
		test_output_backpressure();
		test_sender_pause();
		test_random_stream();

		// All bytes are in: drop valid, let the last results come out and
		// then keep watching the output for any stray result.
		in_valid <= 1'b0;
		waited = 0;
		while (pending_frames.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_frames.size() != 0) begin
			$display("testbench: %0d decoded frames never came out", pending_frames.size());
			fail_count += pending_frames.size();
		end

		$display("testbench: %0d bytes sent, %0d frames checked (accel %0d, rate %0d, angle %0d, other %0d)",
			bytes_sent, results_seen, kind_seen[KIND_ACCEL], kind_seen[KIND_RATE],
			kind_seen[KIND_ANGLE], kind_seen[KIND_OTHER]);
		$display("testbench: bad frames, noise, long output hold and sender pauses included; %0d failures",
			fail_count);
		if (fail_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
